// ===== rtl/core/rme_pkg.sv =====
// Shared types and constants of the register machine executor.
package rme_pkg;

    localparam int AW     = 10;
    localparam int REGS   = 1 << AW;
    localparam int VAL_W  = 32;
    localparam int OP_W   = 4;
    localparam int TGT_W  = 8;
    localparam int CNT_W  = 11;
    localparam int PLEN_W = 9;

    localparam logic [OP_W-1:0] OP_ZERO   = 4'd0;
    localparam logic [OP_W-1:0] OP_INC    = 4'd1;
    localparam logic [OP_W-1:0] OP_MOVE   = 4'd2;
    localparam logic [OP_W-1:0] OP_JUMP   = 4'd3;
    localparam logic [OP_W-1:0] OP_JEQ    = 4'd4;
    localparam logic [OP_W-1:0] OP_ZRANGE = 4'd5;
    localparam logic [OP_W-1:0] OP_SET    = 4'd6;
    localparam logic [OP_W-1:0] OP_COPY   = 4'd7;
    localparam logic [OP_W-1:0] OP_READ   = 4'd8;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [AW-1:0]    reg_a;
        logic [AW-1:0]    reg_b;
        logic [VAL_W-1:0] value;
        logic [TGT_W-1:0] target;
        logic [CNT_W-1:0] count;
    } t_in;

    typedef struct packed {
        logic [VAL_W-1:0] cell_value;
        logic             is_data;
        logic             jump_taken;
        logic [TGT_W-1:0] next_index;
        logic             halt;
        logic             last;
    } t_out;

    // Controller to datapath.
    typedef struct packed {
        logic clr_step;
        logic load;
        logic exec;
        logic zero_step;
        logic cp_rd_issue;
        logic cp_wr_issue;
        logic cp_phase;
        logic idx_clear;
        logic rd_issue;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic [OP_W-1:0] in_op;
        logic            in_empty;
        logic            clr_last;
        logic            walk_last;
        logic            out_free;
    } t_sts;

endpackage

// ===== rtl/core/rme_ctrl.sv =====
// Sequencer of the register machine executor.
module rme_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rme_pkg::t_sts i_sts,
    output rme_pkg::t_cmd o_cmd
);
    import rme_pkg::*;

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b00_0000_0001,
        S_IDLE   = 10'b00_0000_0010,
        S_EXEC   = 10'b00_0000_0100,
        S_ZERO   = 10'b00_0000_1000,
        S_CPR    = 10'b00_0001_0000,
        S_CPRD   = 10'b00_0010_0000,
        S_CPW    = 10'b00_0100_0000,
        S_CPWD   = 10'b00_1000_0000,
        S_READ   = 10'b01_0000_0000,
        S_RDRAIN = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                    if (!i_sts.in_empty) begin
                        case (i_sts.in_op)
                            OP_ZRANGE: n_state = S_ZERO;
                            OP_COPY:   n_state = S_CPR;
                            OP_READ:   n_state = S_READ;
                            default:   n_state = S_EXEC;
                        endcase
                    end
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_ZERO: begin
                o_cmd.zero_step = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = S_EXEC;
                end
            end
            S_CPR: begin
                o_cmd.cp_rd_issue = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = S_CPRD;
                end
            end
            S_CPRD: begin
                // drain the last buffer write, restart the walk for the write phase
                o_cmd.idx_clear = 1'b1;
                n_state         = S_CPW;
            end
            S_CPW: begin
                o_cmd.cp_phase    = 1'b1;
                o_cmd.cp_wr_issue = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = S_CPWD;
                end
            end
            S_CPWD: begin
                o_cmd.cp_phase = 1'b1;
                n_state        = S_EXEC;
            end
            S_READ: begin
                o_cmd.rd_issue = i_sts.out_free;
                if (i_sts.out_free && i_sts.walk_last) begin
                    n_state = S_RDRAIN;
                end
            end
            S_RDRAIN: begin
                // hold until the last cell transfer leaves the read register
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// ===== rtl/core/rme_dpath.sv =====
// Register file, copy buffer, walk counters and result registers.
module rme_dpath #(
    parameter int MAX_READ = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rme_pkg::t_in               i_in_data,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output rme_pkg::t_out              o_out_data,
    input  logic                       i_cfg_we,
    input  logic [rme_pkg::PLEN_W-1:0] i_cfg_wdata,
    input  rme_pkg::t_cmd              i_cmd,
    output rme_pkg::t_sts              o_sts
);
    import rme_pkg::*;

    localparam logic [AW-1:0] RD_LIM = AW'(MAX_READ - 1);

    logic [VAL_W-1:0]  r_regfile [REGS];
    logic [VAL_W-1:0]  r_copybuf [REGS];

    logic [OP_W-1:0]   r_op;
    logic [AW-1:0]     r_a;
    logic [AW-1:0]     r_b;
    logic [VAL_W-1:0]  r_value;
    logic [TGT_W-1:0]  r_target;
    logic [AW-1:0]     r_lenm1;
    logic [AW-1:0]     r_idx;
    logic [AW-1:0]     r_widx;
    logic              r_wpend;
    logic [VAL_W-1:0]  r_rd0;
    logic [VAL_W-1:0]  r_rd1;
    logic [VAL_W-1:0]  r_bufrd;
    logic              r_dvalid;
    logic              r_dlast;
    logic              r_ovalid;
    t_out              r_out;
    logic [PLEN_W-1:0] r_plen;

    logic [AW-1:0]     in_diff;
    logic              in_rev;
    logic [AW-1:0]     in_lenm1;
    logic              in_empty;
    logic              out_free;
    logic              walk_last;
    logic [AW-1:0]     walk_addr_a;
    logic [AW-1:0]     walk_addr_b;
    logic              re0;
    logic [AW-1:0]     addr0;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [VAL_W-1:0]  mem_wdata;
    logic [VAL_W-1:0]  inc_val;
    logic              buf_we;
    logic              tgt_ok;
    logic              jt;
    logic              halt;
    logic              step;
    t_out              ctrl_item;
    t_out              data_item;

    // Range length of the incoming item, minus one, and its empty case.
    assign in_diff = i_in_data.reg_b - i_in_data.reg_a;
    assign in_rev  = i_in_data.reg_a > i_in_data.reg_b;

    always_comb begin
        in_empty = 1'b0;
        in_lenm1 = in_diff;
        case (i_in_data.op)
            OP_ZRANGE: begin
                in_empty = in_rev;
            end
            OP_COPY: begin
                in_empty = (i_in_data.count == '0);
                in_lenm1 = i_in_data.count[CNT_W-1] ? '1
                         : i_in_data.count[AW-1:0] - AW'(1);
            end
            OP_READ: begin
                in_empty = in_rev;
                in_lenm1 = (in_diff > RD_LIM) ? RD_LIM : in_diff;
            end
            default: begin
                in_empty = 1'b0;
            end
        endcase
    end

    assign o_out_valid = r_ovalid | r_dvalid;
    assign out_free    = !o_out_valid || i_out_ready;
    assign walk_last   = (r_idx == r_lenm1);
    assign walk_addr_a = r_a + r_idx;
    assign walk_addr_b = r_b + r_widx;

    assign o_sts.in_op     = i_in_data.op;
    assign o_sts.in_empty  = in_empty;
    assign o_sts.clr_last  = &r_idx;
    assign o_sts.walk_last = walk_last;
    assign o_sts.out_free  = out_free;

    assign inc_val = (&r_rd0) ? r_rd0 : r_rd0 + VAL_W'(1);

    assign re0   = i_cmd.load | i_cmd.cp_rd_issue | i_cmd.rd_issue;
    assign addr0 = i_cmd.load ? i_in_data.reg_a : walk_addr_a;

    // One write port shared by clear, single-cell ops, range zero and copy-back.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = '0;
        if (i_cmd.clr_step) begin
            mem_we = 1'b1;
        end else if (i_cmd.zero_step) begin
            mem_we    = 1'b1;
            mem_waddr = walk_addr_a;
        end else if (i_cmd.exec) begin
            case (r_op)
                OP_ZERO: begin
                    mem_we    = 1'b1;
                    mem_waddr = r_a;
                end
                OP_INC: begin
                    mem_we    = 1'b1;
                    mem_waddr = r_a;
                    mem_wdata = inc_val;
                end
                OP_MOVE: begin
                    mem_we    = 1'b1;
                    mem_waddr = r_b;
                    mem_wdata = r_rd0;
                end
                OP_SET: begin
                    mem_we    = 1'b1;
                    mem_waddr = r_a;
                    mem_wdata = r_value;
                end
                default: begin
                    mem_we = 1'b0;
                end
            endcase
        end else if (i_cmd.cp_phase && r_wpend) begin
            mem_we    = 1'b1;
            mem_waddr = walk_addr_b;
            mem_wdata = r_bufrd;
        end
    end

    assign buf_we = r_wpend && !i_cmd.cp_phase;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_regfile[mem_waddr] <= mem_wdata;
        end
        if (re0) begin
            r_rd0 <= r_regfile[addr0];
        end
        if (i_cmd.load) begin
            r_rd1 <= r_regfile[i_in_data.reg_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (buf_we) begin
            r_copybuf[r_widx] <= r_rd0;
        end
        if (i_cmd.cp_wr_issue) begin
            r_bufrd <= r_copybuf[r_idx];
        end
    end

    // Control result of the finished instruction.
    assign tgt_ok = (r_target != '0) && ({1'b0, r_target} < r_plen);

    always_comb begin
        jt   = 1'b0;
        halt = 1'b0;
        case (r_op)
            OP_JUMP: begin
                jt   = tgt_ok;
                halt = !tgt_ok;
            end
            OP_JEQ: begin
                if (r_rd0 == r_rd1) begin
                    jt   = tgt_ok;
                    halt = !tgt_ok;
                end
            end
            OP_ZERO, OP_INC, OP_MOVE, OP_ZRANGE, OP_SET, OP_COPY, OP_READ: begin
                jt = 1'b0;
            end
            default: begin
                halt = 1'b1;
            end
        endcase
    end

    always_comb begin
        ctrl_item            = '0;
        ctrl_item.jump_taken = jt;
        ctrl_item.next_index = jt ? r_target : '0;
        ctrl_item.halt       = halt;
        ctrl_item.last       = 1'b1;
        data_item            = '0;
        data_item.cell_value = r_rd0;
        data_item.is_data    = 1'b1;
        data_item.last       = r_dlast;
    end

    assign o_out_data = r_dvalid ? data_item : r_out;

    assign step = i_cmd.clr_step | i_cmd.zero_step | i_cmd.cp_rd_issue
                | i_cmd.cp_wr_issue | i_cmd.rd_issue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_wpend  <= 1'b0;
            r_dvalid <= 1'b0;
            r_ovalid <= 1'b0;
            r_plen   <= '0;
        end else begin
            if (i_cmd.load || i_cmd.idx_clear) begin
                r_idx <= '0;
            end else if (step) begin
                r_idx <= r_idx + AW'(1);
            end
            r_wpend <= i_cmd.cp_rd_issue | i_cmd.cp_wr_issue;
            if (i_cmd.rd_issue) begin
                r_dvalid <= 1'b1;
            end else if (i_out_ready) begin
                r_dvalid <= 1'b0;
            end
            if (i_cmd.exec && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_plen <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_in_data.op;
            r_a      <= i_in_data.reg_a;
            r_b      <= i_in_data.reg_b;
            r_value  <= i_in_data.value;
            r_target <= i_in_data.target;
            r_lenm1  <= in_lenm1;
        end
        r_widx <= r_idx;
        if (i_cmd.rd_issue) begin
            r_dlast <= walk_last;
        end
        if (i_cmd.exec && out_free) begin
            r_out <= ctrl_item;
        end
    end

endmodule

// ===== rtl/core/register_machine_executor_top.sv =====
// Top level of the register machine executor.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_in_data  (t_in)
//  out     | output    | o_out_valid / i_out_ready  | o_out_data (t_out)
//  cfg     | input     | i_cfg_we                   | i_cfg_wdata (program length)
//
// After reset the block sweeps the 1024-cell register file to zero, one cell a
// cycle, with o_in_ready low; config writes are taken meanwhile.
// Single-cell ops and jumps do a register file read, then the write and result.
// Range zero walks its cells and then gives the result; copy reads into a buffer, then
// writes back; read sends one cell a cycle; each walk uses the single write port or one read port.
// A held output stalls the read stream and the final result; one item is worked at a time.
module register_machine_executor_top #(
    parameter int MAX_READ = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  rme_pkg::t_in               i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output rme_pkg::t_out              o_out_data,
    input  logic                       i_cfg_we,
    input  logic [rme_pkg::PLEN_W-1:0] i_cfg_wdata
);
    import rme_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    rme_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rme_dpath #(
        .MAX_READ (MAX_READ)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

    a_no_data_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !(o_out_valid && o_out_data.is_data))
        else $error("read data pending while a new instruction can enter");

    a_ctrl_item_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.is_data) |-> o_out_data.last)
        else $error("control item without last mark");

    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.clr_step, w_cmd.load, w_cmd.exec, w_cmd.zero_step,
                  w_cmd.cp_rd_issue, w_cmd.cp_wr_issue, w_cmd.rd_issue}))
        else $error("more than one datapath action in a cycle");

    a_read_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rd_issue |-> w_sts.out_free)
        else $error("read issued while output slot is held");

endmodule
